// ===== rtl/core/pmsrfp_pkg.sv =====
`timescale 1ns / 1ps

package pmsrfp_pkg;

  // Frame layout
  localparam logic [7:0] FRAME_HEAD    = 8'h40;
  localparam logic [7:0] FRAME_LENGTH  = 8'h0D;
  localparam logic [7:0] FRAME_COMMAND = 8'h04;

  localparam int BYTE_W      = 8;
  localparam int READING_W   = 16;
  localparam int NUM_READ    = 4;
  localparam int RD_BYTES    = 2 * NUM_READ;
  localparam int RD_IDX_W    = $clog2(RD_BYTES);
  localparam int POS_W       = 4;
  localparam int OUT_DATA_W  = NUM_READ * READING_W;
  localparam int STATUS_W    = 3;

  // Frame positions: index of the next byte expected
  localparam logic [POS_W-1:0] POS_HEAD    = 4'd0;
  localparam logic [POS_W-1:0] POS_LEN     = 4'd1;
  localparam logic [POS_W-1:0] POS_CMD     = 4'd2;
  localparam logic [POS_W-1:0] POS_DATA0   = 4'd3;
  localparam logic [POS_W-1:0] POS_RD_LAST = 4'd10;
  localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd14;
  localparam logic [POS_W-1:0] POS_CHECK   = 4'd15;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_HEAD = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_CMD  = 3'd3,
    ST_BAD_SUM  = 3'd4
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [READING_W-1:0]   pm10;
    logic [READING_W-1:0]   pm4;
    logic [READING_W-1:0]   pm25;
    logic [READING_W-1:0]   pm1;
  } result_t;

endpackage

// ===== rtl/core/pmsrfp_out_skid.sv =====
`timescale 1ns / 1ps

// Result register with one skid entry, so the parser keeps taking bytes
// while a result waits at the output.
module pmsrfp_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  pmsrfp_pkg::result_t res,
  output logic              room,
  output logic              out_vld,
  input  logic              out_rdy,
  output pmsrfp_pkg::result_t out_res
);
  import pmsrfp_pkg::*;

  logic    o_vld_r, o_vld_nxt;
  logic    s_vld_r, s_vld_nxt;
  result_t o_res_r, o_res_nxt;
  result_t s_res_r, s_res_nxt;

  // Output stage reloads when empty or drained; skid catches a stalled result
  always_comb begin
    o_vld_nxt = o_vld_r;
    o_res_nxt = o_res_r;
    s_vld_nxt = s_vld_r;
    s_res_nxt = s_res_r;
    if (out_rdy || !o_vld_r) begin
      if (s_vld_r) begin
        o_vld_nxt = 1'b1;
        o_res_nxt = s_res_r;
        s_vld_nxt = 1'b0;
      end else begin
        o_vld_nxt = res_vld;
        o_res_nxt = res;
      end
    end else if (res_vld) begin
      s_vld_nxt = 1'b1;
      s_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      o_vld_r <= o_vld_nxt;
      s_vld_r <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_res_r <= o_res_nxt;
    s_res_r <= s_res_nxt;
  end

  assign room    = !s_vld_r;
  assign out_vld = o_vld_r;
  assign out_res = o_res_r;

endmodule

// ===== rtl/core/pm_sensor_response_frame_parser.sv =====
`timescale 1ns / 1ps

// A result is registered in the output stage, or in the skid entry while the output is stalled.
// Throughput: one received byte per cycle while in_tready is high; each byte is handled in the cycle it is taken.
// A second stalled result fills the skid entry, and in_tready drops until it drains.
// Reset (rst_n low, synchronous): parser waits for a head byte, checksum cleared,
// output and skid empty; captured reading bytes are not cleared.
module pm_sensor_response_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] pm1_reading, [31:16] pm25_reading,
                                  // [47:32] pm4_reading, [63:48] pm10_reading
  output logic [2:0]  out_tuser   // [2:0] status
);
  import pmsrfp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              skip_r, skip_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] rd_r [RD_BYTES];
  logic [BYTE_W-1:0] total;
  logic [RD_IDX_W-1:0] rd_idx;
  logic              rd_we;
  logic              accept;
  logic              res_vld;
  logic              room;
  result_t           res;
  result_t           out_res;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = room;
  assign total     = sum_r + in_tdata;
  assign rd_idx    = RD_IDX_W'(pos_r - POS_DATA0);

  // Frame tracking and checksum
  always_comb begin
    pos_nxt  = pos_r;
    skip_nxt = skip_r;
    sum_nxt  = sum_r;
    res_vld  = 1'b0;
    rd_we    = 1'b0;
    res      = '{status: ST_OK, default: '0};
    if (accept) begin
      if (skip_r) begin
        // byte after a rejected head is dropped
        skip_nxt = 1'b0;
      end else begin
        case (pos_r) inside
          POS_LEN: begin
            if (in_tdata != FRAME_LENGTH) begin
              pos_nxt    = POS_HEAD;
              res_vld    = 1'b1;
              res.status = ST_BAD_LEN;
            end else begin
              sum_nxt = total;
              pos_nxt = POS_CMD;
            end
          end
          POS_CMD: begin
            if (in_tdata != FRAME_COMMAND) begin
              pos_nxt    = POS_HEAD;
              res_vld    = 1'b1;
              res.status = ST_BAD_CMD;
            end else begin
              sum_nxt = total;
              pos_nxt = POS_DATA0;
            end
          end
          [POS_DATA0:POS_DATA_LAST]: begin
            rd_we   = (pos_r <= POS_RD_LAST);
            sum_nxt = total;
            pos_nxt = pos_r + POS_W'(1);
          end
          POS_CHECK: begin
            pos_nxt = POS_HEAD;
            sum_nxt = '0;
            res_vld = 1'b1;
            if (total == '0) begin
              res.status = ST_OK;
              res.pm1    = {rd_r[0], rd_r[1]};
              res.pm25   = {rd_r[2], rd_r[3]};
              res.pm4    = {rd_r[4], rd_r[5]};
              res.pm10   = {rd_r[6], rd_r[7]};
            end else begin
              res.status = ST_BAD_SUM;
            end
          end
          default: begin
            // waiting for the head byte
            if (in_tdata != FRAME_HEAD) begin
              pos_nxt    = POS_HEAD;
              sum_nxt    = '0;
              skip_nxt   = 1'b1;
              res_vld    = 1'b1;
              res.status = ST_BAD_HEAD;
            end else begin
              sum_nxt = in_tdata;
              pos_nxt = POS_LEN;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HEAD;
      skip_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      skip_r <= skip_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Reading bytes, captured from data bytes 0..7
  always_ff @(posedge clk) begin
    if (rd_we) begin
      rd_r[rd_idx] <= in_tdata;
    end
  end

  pmsrfp_out_skid u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res     (res),
    .room    (room),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (out_res)
  );

  assign out_tdata = {out_res.pm10, out_res.pm4, out_res.pm25, out_res.pm1};
  assign out_tuser = out_res.status;

endmodule

// ===== rtl/core/pmsrfp_checker.sv =====
`timescale 1ns / 1ps

module pmsrfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import pmsrfp_pkg::*;

  // Reset leaves the output empty and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("output not empty or input blocked after reset");

  // A stalled result stays on the bus
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  // Only the defined status codes come out
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= 3'(ST_BAD_SUM)))
    else $error("undefined status code");

  // Any error status carries zero readings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != 3'(ST_OK))) |-> (out_tdata == '0))
    else $error("error result with nonzero readings");

endmodule

bind pm_sensor_response_frame_parser pmsrfp_checker u_pmsrfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
